>>> rtl/iirdf1_pkg.sv
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared types and constants of the direct form I IIR filter.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

	// Requested order, clamped into the range the history supports.
	localparam int FILTER_ORDER = 3;
	localparam int HIST_DEPTH   = 3;
	localparam int EFF_ORDER    = (FILTER_ORDER < 1) ? 1 :
	                              (FILTER_ORDER > HIST_DEPTH) ? HIST_DEPTH : FILTER_ORDER;

	// One product for b0, then one per b and one per a tap.
	localparam int NUM_TAPS = 1 + 2 * EFF_ORDER;
	localparam int TAP_W    = $clog2(NUM_TAPS);
	localparam int HIDX_W   = $clog2(HIST_DEPTH);

	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 32;
	localparam int ACC_W    = 36;
	localparam int FRAC_SH  = 14;
	localparam int YFULL_W  = ACC_W - FRAC_SH;

	// Opcodes of the input request.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// Register map indexes.
	localparam int NUM_REGS = 7;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_NUM0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NUM1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_NUM2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_NUM3 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DEN1 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DEN2 = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_DEN3 = 3'd6;

	localparam logic signed [15:0] NUM0_RESET = 16'sd16384;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [15:0]         coef_t;

	typedef struct packed {
		logic    opcode;
		sample_t sample_in;
	} in_req_t;

	typedef struct packed {
		sample_t sample_out;
		logic    saturated;
	} out_req_t;

	// num[0..3] = b0..b3, den[0..2] = a1..a3
	typedef struct packed {
		coef_t [3:0] num;
		coef_t [2:0] den;
	} coefs_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             start;
		logic             clear_hist;
		logic             mac_en;
		logic [TAP_W-1:0] tap;
		logic             finish;
	} dp_cmd_t;

endpackage

>>> rtl/iir_direct_form_one_filter.sv
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter
// Direct form I IIR filter, order up to three, Q1.15 samples, Q2.14 coefs.
// ----------------------------------------------------------------------------
// A sample request passes through an accept step in the idle state, a MAC
// phase in which the single shared 16x16 multiplier works through b0..bN and
// a1..aN, a drain step that adds the last product, and a final step that
// rounds, saturates and shifts the histories; only then is the next request
// accepted. A clear request is taken while idle, zeroes both histories and
// returns nothing. The result sits in an output register, so a following
// request is accepted while the previous result is still stalled; the block
// only waits at the final step if that register is still full.
// Coefficients are written over APB at byte address 4*i (b0..b3, a1..a3),
// already normalized by a0; write them only while the filter is idle.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter
	import iirdf1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// sample requests
	input  logic        req_valid,
	output logic        req_stall,
	input  in_req_t     req,
	// results
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output out_req_t    rsp,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	coefs_t  coefs;
	dp_cmd_t cmd;

	// coefficient registers
	iirdf1_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coefs   (coefs)
	);

	// sequencer: tap counter, request and result handshakes
	iirdf1_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_opcode (req.opcode),
		.req_stall  (req_stall),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.cmd        (cmd)
	);

	// multiply-accumulate datapath with histories and result register
	iirdf1_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample_in (req.sample_in),
		.coefs     (coefs),
		.rsp       (rsp)
	);

endmodule

>>> rtl/iirdf1_regs.sv
// ----------------------------------------------------------------------------
// iirdf1_regs
// APB coefficient register file.
// ----------------------------------------------------------------------------
module iirdf1_regs
	import iirdf1_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output coefs_t      coefs
);

	coefs_t coefs_q;
	logic [REG_IDX_W-1:0] idx;
	logic wr;

	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign coefs  = coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.num[3:1] <= '0;
			coefs_q.num[0]   <= NUM0_RESET;
			coefs_q.den      <= '0;
		end else if (wr) begin
			case (idx)
				REG_NUM0: coefs_q.num[0] <= pwdata[15:0];
				REG_NUM1: coefs_q.num[1] <= pwdata[15:0];
				REG_NUM2: coefs_q.num[2] <= pwdata[15:0];
				REG_NUM3: coefs_q.num[3] <= pwdata[15:0];
				REG_DEN1: coefs_q.den[0] <= pwdata[15:0];
				REG_DEN2: coefs_q.den[1] <= pwdata[15:0];
				REG_DEN3: coefs_q.den[2] <= pwdata[15:0];
				default: ;  // unmapped: ignored
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_NUM0: prdata = {16'd0, coefs_q.num[0]};
			REG_NUM1: prdata = {16'd0, coefs_q.num[1]};
			REG_NUM2: prdata = {16'd0, coefs_q.num[2]};
			REG_NUM3: prdata = {16'd0, coefs_q.num[3]};
			REG_DEN1: prdata = {16'd0, coefs_q.den[0]};
			REG_DEN2: prdata = {16'd0, coefs_q.den[1]};
			REG_DEN3: prdata = {16'd0, coefs_q.den[2]};
			default:  prdata = 32'd0;
		endcase
	end

endmodule

>>> rtl/iirdf1_dp.sv
// ----------------------------------------------------------------------------
// iirdf1_dp
// Datapath: histories, shared multiplier, accumulator, round and saturate.
// ----------------------------------------------------------------------------
module iirdf1_dp
	import iirdf1_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	input  sample_t  sample_in,
	input  coefs_t   coefs,
	output out_req_t rsp
);

	sample_t [HIST_DEPTH-1:0] xh_q;
	sample_t [HIST_DEPTH-1:0] yh_q;
	sample_t                  u_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     sub_s1;
	logic                     prod_valid_s1;
	out_req_t                 rsp_q;

	// operand select
	coef_t             op_coef;
	sample_t           op_data;
	logic              op_sub;
	logic [HIDX_W-1:0] hidx;

	always_comb begin
		hidx    = '0;
		op_coef = coefs.num[0];
		op_data = u_q;
		op_sub  = 1'b0;
		if (cmd.tap == '0) begin
			hidx = '0;
		end else if (cmd.tap <= TAP_W'(EFF_ORDER)) begin
			hidx    = HIDX_W'(cmd.tap - TAP_W'(1));
			op_coef = coefs.num[hidx + HIDX_W'(1)];
			op_data = xh_q[hidx];
		end else begin
			hidx    = HIDX_W'(cmd.tap - TAP_W'(1) - TAP_W'(EFF_ORDER));
			op_coef = coefs.den[hidx];
			op_data = yh_q[hidx];
			op_sub  = 1'b1;
		end
	end

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s1 <= 1'b0;
		end else begin
			prod_valid_s1 <= cmd.mac_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_en) begin
			prod_s1 <= op_coef * op_data;
			sub_s1  <= op_sub;
		end
	end

	// accumulate stage
	logic signed [ACC_W-1:0] prod_ext;
	assign prod_ext = ACC_W'(prod_s1);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			u_q   <= sample_in;
			acc_q <= '0;
		end else if (prod_valid_s1) begin
			acc_q <= sub_s1 ? acc_q - prod_ext : acc_q + prod_ext;
		end
	end

	// round half up to Q1.15, then clip
	logic signed [ACC_W-1:0]   acc_rnd;
	logic signed [YFULL_W-1:0] y_full;
	sample_t                   y_sat;
	logic                      sat;

	assign acc_rnd = acc_q + ACC_W'(1 << (FRAC_SH - 1));
	assign y_full  = YFULL_W'(acc_rnd >>> FRAC_SH);

	always_comb begin
		if (y_full > YFULL_W'(32767)) begin
			y_sat = 16'sh7FFF;
			sat   = 1'b1;
		end else if (y_full < -YFULL_W'(32768)) begin
			y_sat = 16'sh8000;
			sat   = 1'b1;
		end else begin
			y_sat = y_full[SAMPLE_W-1:0];
			sat   = 1'b0;
		end
	end

	// histories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xh_q <= '0;
			yh_q <= '0;
		end else if (cmd.clear_hist) begin
			xh_q <= '0;
			yh_q <= '0;
		end else if (cmd.finish) begin
			for (int i = 1; i < HIST_DEPTH; i++) begin
				if (i < EFF_ORDER) begin
					xh_q[i] <= xh_q[i-1];
					yh_q[i] <= yh_q[i-1];
				end
			end
			xh_q[0] <= u_q;
			yh_q[0] <= y_sat;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q.sample_out <= y_sat;
			rsp_q.saturated  <= sat;
		end
	end

	assign rsp = rsp_q;

endmodule

>>> rtl/iirdf1_ctrl.sv
// ----------------------------------------------------------------------------
// iirdf1_ctrl
// Sequencer: steps the multiply-accumulate taps and owns the handshakes.
// ----------------------------------------------------------------------------
module iirdf1_ctrl
	import iirdf1_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	input  logic    req_opcode,
	output logic    req_stall,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_MAC   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	logic [TAP_W-1:0] tap_q, tap_d;
	logic             rsp_valid_q;
	logic             out_free;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d        = state_q;
		tap_d          = tap_q;
		cmd            = '0;
		cmd.tap        = tap_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_opcode == OP_CLEAR) begin
						cmd.clear_hist = 1'b1;
					end else begin
						cmd.start = 1'b1;
						tap_d     = '0;
						state_d   = S_MAC;
					end
				end
			end
			S_MAC: begin
				cmd.mac_en = 1'b1;
				tap_d      = tap_q + TAP_W'(1);
				if (tap_q == TAP_W'(NUM_TAPS - 1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tap_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
			if (cmd.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
